### rtl/srr_pkg.sv
// ----------------------------------------------------------------------------
// srr_pkg
// Shared types and constants of the selective-repeat receiver.
// ----------------------------------------------------------------------------
package srr_pkg;

  // Default configuration
  localparam int SEQ_BITS_DEF     = 3;
  localparam int WINDOW_DEF       = 4;
  localparam int PAYLOAD_BITS_DEF = 32;

  // Fixed field widths on the stream ports
  localparam int SEQ_PORT_W   = 3;
  localparam int DATA_PORT_W  = 32;
  localparam int IN_TDATA_W   = ((SEQ_PORT_W + DATA_PORT_W + 7) / 8) * 8;
  localparam int IN_TUSER_W   = 1;
  localparam int OUT_TDATA_W  = ((SEQ_PORT_W + DATA_PORT_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W  = 2;

  // Result kind codes
  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_NACK = 1'b1;

  // Frame class decided at the front
  typedef enum logic {
    CLS_GOOD    = 1'b0,
    CLS_CORRUPT = 1'b1
  } srr_class_e;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_DRAIN = 2'd1,
    ST_NACK  = 2'd2
  } srr_state_e;

  // Flags travelling with each result
  typedef struct packed {
    logic kind;
    logic deliver;
    logic last;
  } srr_flags_t;

endpackage

### rtl/srr_front.sv
// ----------------------------------------------------------------------------
// srr_front
// Accepts frames, classifies them by checksum and queues them (two entries)
// for the back end.
// ----------------------------------------------------------------------------
module srr_front #(
  parameter int SEQ_BITS     = srr_pkg::SEQ_BITS_DEF,
  parameter int PAYLOAD_BITS = srr_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_valid_i,
  output logic                             s_ready_o,
  input  logic [srr_pkg::SEQ_PORT_W-1:0]   s_seq_i,
  input  logic                             s_crc_ok_i,
  input  logic [srr_pkg::DATA_PORT_W-1:0]  s_payload_i,
  output logic                             q_valid_o,
  input  logic                             q_pop_i,
  output srr_pkg::srr_class_e              q_class_o,
  output logic [SEQ_BITS-1:0]              q_seq_o,
  output logic [PAYLOAD_BITS-1:0]          q_payload_o
);
  import srr_pkg::*;

  localparam int SW = (SEQ_BITS > SEQ_PORT_W) ? SEQ_BITS : SEQ_PORT_W;
  localparam int PW = (PAYLOAD_BITS > DATA_PORT_W) ? PAYLOAD_BITS : DATA_PORT_W;

  logic [SW-1:0]           seq_ext;
  logic [PW-1:0]           pay_ext;
  srr_class_e              cls_in;
  logic                    push;

  srr_class_e              cls_q [2];
  logic [SEQ_BITS-1:0]     seq_q [2];
  logic [PAYLOAD_BITS-1:0] pay_q [2];
  logic                    wr_ptr_q, wr_ptr_d;
  logic                    rd_ptr_q, rd_ptr_d;
  logic [1:0]              cnt_q, cnt_d;

  assign seq_ext = SW'(s_seq_i);
  assign pay_ext = PW'(s_payload_i);
  assign cls_in  = s_crc_ok_i ? CLS_GOOD : CLS_CORRUPT;

  assign s_ready_o = (cnt_q != 2'd2);
  assign push      = s_valid_i && s_ready_o;
  assign q_valid_o = (cnt_q != 2'd0);

  assign q_class_o   = cls_q[rd_ptr_q];
  assign q_seq_o     = seq_q[rd_ptr_q];
  assign q_payload_o = pay_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = q_pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      cls_q[wr_ptr_q] <= cls_in;
      seq_q[wr_ptr_q] <= seq_ext[SEQ_BITS-1:0];
      pay_q[wr_ptr_q] <= pay_ext[PAYLOAD_BITS-1:0];
    end
  end

endmodule

### rtl/srr_back.sv
// ----------------------------------------------------------------------------
// srr_back
// Window tracking, held-frame store and result sequencer with an output
// register.
// ----------------------------------------------------------------------------
module srr_back #(
  parameter int SEQ_BITS     = srr_pkg::SEQ_BITS_DEF,
  parameter int WINDOW       = srr_pkg::WINDOW_DEF,
  parameter int PAYLOAD_BITS = srr_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_valid_i,
  output logic                    q_pop_o,
  input  srr_pkg::srr_class_e     q_class_i,
  input  logic [SEQ_BITS-1:0]     q_seq_i,
  input  logic [PAYLOAD_BITS-1:0] q_payload_i,
  output logic                    r_valid_o,
  input  logic                    r_ready_i,
  output srr_pkg::srr_flags_t     r_flags_o,
  output logic [SEQ_BITS-1:0]     r_seq_o,
  output logic [PAYLOAD_BITS-1:0] r_data_o
);
  import srr_pkg::*;

  localparam int SC = 1 << SEQ_BITS;
  localparam int RW = (WINDOW > 1) ? $clog2(WINDOW + 1) : 1;

  srr_state_e              state_q, state_d;
  logic [SEQ_BITS-1:0]     exp_q, exp_d;
  logic [RW-1:0]           rel_q, rel_d;
  logic [SC-1:0]           mark_q;
  logic [PAYLOAD_BITS-1:0] mem [SC];
  logic [PAYLOAD_BITS-1:0] rd_data_q;

  logic                    ov_q, ov_d;
  srr_flags_t              oflags_q, oflags_d;
  logic [SEQ_BITS-1:0]     oseq_q, oseq_d;
  logic [PAYLOAD_BITS-1:0] odata_q, odata_d;

  logic                    can_emit;
  logic                    emit;
  logic                    mark_set, mark_clr, wr_en;
  logic [SEQ_BITS-1:0]     seq_gap, seq_nxt, exp_nxt;
  logic                    in_win;

  assign can_emit = !ov_q || r_ready_i;
  assign seq_gap  = q_seq_i - exp_q;
  assign in_win   = (32'(seq_gap) < 32'(WINDOW));
  assign seq_nxt  = q_seq_i + SEQ_BITS'(1);
  assign exp_nxt  = exp_q + SEQ_BITS'(1);

  always_comb begin
    state_d  = state_q;
    exp_d    = exp_q;
    rel_d    = rel_q;
    q_pop_o  = 1'b0;
    emit     = 1'b0;
    mark_set = 1'b0;
    mark_clr = 1'b0;
    wr_en    = 1'b0;
    oflags_d = oflags_q;
    oseq_d   = oseq_q;
    odata_d  = odata_q;

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i && can_emit) begin
          q_pop_o = 1'b1;
          if (q_class_i == CLS_CORRUPT) begin
            emit     = 1'b1;
            oflags_d = '{kind: KIND_NACK, deliver: 1'b0, last: 1'b1};
            oseq_d   = exp_q;
            odata_d  = '0;
          end else if (q_seq_i == exp_q) begin
            emit   = 1'b1;
            oseq_d = q_seq_i;
            odata_d = q_payload_i;
            exp_d  = seq_nxt;
            rel_d  = '0;
            if (mark_q[seq_nxt] && (WINDOW > 1)) begin
              oflags_d = '{kind: KIND_ACK, deliver: 1'b1, last: 1'b0};
              state_d  = ST_DRAIN;
            end else begin
              oflags_d = '{kind: KIND_ACK, deliver: 1'b1, last: 1'b1};
            end
          end else if (in_win) begin
            if (!mark_q[q_seq_i]) begin
              // hold the new frame and acknowledge it
              emit     = 1'b1;
              wr_en    = 1'b1;
              mark_set = 1'b1;
              oflags_d = '{kind: KIND_ACK, deliver: 1'b0, last: mark_q[exp_q]};
              oseq_d   = q_seq_i;
              odata_d  = '0;
              if (!mark_q[exp_q]) begin
                state_d = ST_NACK;
              end
            end else if (!mark_q[exp_q]) begin
              emit     = 1'b1;
              oflags_d = '{kind: KIND_NACK, deliver: 1'b0, last: 1'b1};
              oseq_d   = exp_q;
              odata_d  = '0;
            end
          end
        end
      end

      ST_DRAIN: begin
        if (can_emit) begin
          // release one held frame
          emit     = 1'b1;
          mark_clr = 1'b1;
          oseq_d   = exp_q;
          odata_d  = rd_data_q;
          exp_d    = exp_nxt;
          rel_d    = rel_q + RW'(1);
          if (mark_q[exp_nxt] && ((32'(rel_q) + 32'd2) < 32'(WINDOW))) begin
            oflags_d = '{kind: KIND_ACK, deliver: 1'b1, last: 1'b0};
          end else begin
            oflags_d = '{kind: KIND_ACK, deliver: 1'b1, last: 1'b1};
            state_d  = ST_IDLE;
          end
        end
      end

      ST_NACK: begin
        if (can_emit) begin
          emit     = 1'b1;
          oflags_d = '{kind: KIND_NACK, deliver: 1'b0, last: 1'b1};
          oseq_d   = exp_q;
          odata_d  = '0;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (emit) begin
      ov_d = 1'b1;
    end else if (r_ready_i) begin
      ov_d = 1'b0;
    end else begin
      ov_d = ov_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      exp_q   <= '0;
      rel_q   <= '0;
      mark_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      exp_q   <= exp_d;
      rel_q   <= rel_d;
      ov_q    <= ov_d;
      if (mark_set) begin
        mark_q[q_seq_i] <= 1'b1;
      end
      if (mark_clr) begin
        mark_q[exp_q] <= 1'b0;
      end
    end
  end

  // Held payload store; read address tracks the next expected number
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[q_seq_i] <= q_payload_i;
    end
    rd_data_q <= mem[exp_d];
  end

  always_ff @(posedge clk_i) begin
    oflags_q <= oflags_d;
    oseq_q   <= oseq_d;
    odata_q  <= odata_d;
  end

  assign r_valid_o = ov_q;
  assign r_flags_o = oflags_q;
  assign r_seq_o   = oseq_q;
  assign r_data_o  = odata_q;

endmodule

### rtl/selective_repeat_receiver.sv
// ----------------------------------------------------------------------------
// The first result of a frame is valid once the frame has passed the front queue
// and the back end's output register. Throughput: one result per cycle while the
// result side is ready; a frame causes 1 to WINDOW results, or none.
// The back-end sequencer, which owns the held-frame store, produces those results.
// Reset clears expected number and all held marks at once; no clearing pass.
// ----------------------------------------------------------------------------
// selective_repeat_receiver
// Selective-repeat ARQ receiver with negative acknowledgements.
// ----------------------------------------------------------------------------
module selective_repeat_receiver #(
  parameter int SEQ_BITS     = srr_pkg::SEQ_BITS_DEF,
  parameter int WINDOW       = srr_pkg::WINDOW_DEF,
  parameter int PAYLOAD_BITS = srr_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // seq[2:0], payload[34:3], zero pad
  input  logic [srr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // crc_ok[0]
  input  logic [srr_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // ack_seq[2:0], out_data[34:3], zero pad
  output logic [srr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // kind[0], deliver[1]
  output logic [srr_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
  output logic                             m_axis_tlast
);
  import srr_pkg::*;

  localparam int SW = (SEQ_BITS > SEQ_PORT_W) ? SEQ_BITS : SEQ_PORT_W;
  localparam int PW = (PAYLOAD_BITS > DATA_PORT_W) ? PAYLOAD_BITS : DATA_PORT_W;

  logic                    q_valid, q_pop;
  srr_class_e              q_class;
  logic [SEQ_BITS-1:0]     q_seq;
  logic [PAYLOAD_BITS-1:0] q_payload;

  srr_flags_t              r_flags;
  logic [SEQ_BITS-1:0]     r_seq;
  logic [PAYLOAD_BITS-1:0] r_data;
  logic [SW-1:0]           seq_ext;
  logic [PW-1:0]           data_ext;

  srr_front #(
    .SEQ_BITS     (SEQ_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_seq_i     (s_axis_tdata[SEQ_PORT_W-1:0]),
    .s_crc_ok_i  (s_axis_tuser[0]),
    .s_payload_i (s_axis_tdata[SEQ_PORT_W +: DATA_PORT_W]),
    .q_valid_o   (q_valid),
    .q_pop_i     (q_pop),
    .q_class_o   (q_class),
    .q_seq_o     (q_seq),
    .q_payload_o (q_payload)
  );

  srr_back #(
    .SEQ_BITS     (SEQ_BITS),
    .WINDOW       (WINDOW),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_class_i   (q_class),
    .q_seq_i     (q_seq),
    .q_payload_i (q_payload),
    .r_valid_o   (m_axis_tvalid),
    .r_ready_i   (m_axis_tready),
    .r_flags_o   (r_flags),
    .r_seq_o     (r_seq),
    .r_data_o    (r_data)
  );

  assign seq_ext  = SW'(r_seq);
  assign data_ext = PW'(r_data);

  assign m_axis_tdata = OUT_TDATA_W'({data_ext[DATA_PORT_W-1:0], seq_ext[SEQ_PORT_W-1:0]});
  assign m_axis_tuser = {r_flags.deliver, r_flags.kind};
  assign m_axis_tlast = r_flags.last;

endmodule

### tb/sv/selective_repeat_receiver_test.sv
// ----------------------------------------------------------------------------
// selective_repeat_receiver_test
// Self-checking bench for the selective-repeat ARQ receiver. A short table of
// frames covers corrupt, in-order, held, duplicate and out-of-window cases,
// the wrap of the sequence space and the longest release run. Random frames
// follow, mostly near the expected number. Every result transaction is
// compared against a behavioural model of the receiver kept in the bench, or
// for some table rows against a result typed by hand. Both stream sides idle
// at random, and the result side also holds off for one long stretch.
// ----------------------------------------------------------------------------
module selective_repeat_receiver_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEQ_N      = 1 << srr_pkg::SEQ_BITS_DEF;
  localparam int WIN        = srr_pkg::WINDOW_DEF;
  localparam int RAND_ACKED = 96;
  localparam int HOLD_LEN   = 150;
  localparam int N_ROWS     = 20;

  typedef struct packed {
    logic        kind;
    logic [2:0]  ack_seq;
    logic        deliver;
    logic [31:0] out_data;
    logic        last;
  } ack_t;

  // One frame of stimulus; the fixed fields carry a result typed by hand
  typedef struct packed {
    logic [2:0]  seq;
    logic        crc_ok;
    logic [31:0] payload;
    logic        fixed;
    logic        has_ack;
    logic        kind;
    logic [2:0]  ack_seq;
    logic        deliver;
    logic [31:0] out_data;
  } frame_row_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [srr_pkg::IN_TDATA_W-1:0]  s_axis_tdata;   // seq[2:0], payload[34:3], zero pad
  logic [srr_pkg::IN_TUSER_W-1:0]  s_axis_tuser;   // crc_ok[0]
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [srr_pkg::OUT_TDATA_W-1:0] m_axis_tdata;   // ack_seq[2:0], out_data[34:3], zero pad
  logic [srr_pkg::OUT_TUSER_W-1:0] m_axis_tuser;   // kind[0], deliver[1]
  logic                            m_axis_tlast;

  // Receiver model state
  logic [2:0]  expected_num;
  logic        held_mark [SEQ_N];
  logic [31:0] held_word [SEQ_N];
  ack_t        frame_acks [WIN];
  int          frame_ack_count;

  ack_t        pending_acks [$];
  int          mismatches;
  int          hold_requests;
  bit          quiet;

  frame_row_t  directed_rows [N_ROWS];

  selective_repeat_receiver u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("selective_repeat_receiver_test NOT OK");
    $finish;
  end

  task automatic add_ack(input logic kind, input logic [2:0] sq, input logic deliver,
                         input logic [31:0] data);
    frame_acks[frame_ack_count] = '{kind, sq, deliver, deliver ? data : 32'h0, 1'b0};
    frame_ack_count++;
  endtask

  // Work out the results of one accepted frame and advance the model
  task automatic compute_acks(input logic [2:0] sq, input logic crc_ok,
                              input logic [31:0] payload);
    int         released;
    logic [2:0] seq_gap;
    released        = 0;
    frame_ack_count = 0;
    seq_gap         = sq - expected_num;
    if (!crc_ok) begin
      add_ack(srr_pkg::KIND_NACK, expected_num, 1'b0, 32'h0);
    end else if (sq == expected_num) begin
      add_ack(srr_pkg::KIND_ACK, sq, 1'b1, payload);
      expected_num = expected_num + 3'd1;
      // release the held run that now follows in order
      while (held_mark[expected_num] && released + 1 < WIN) begin
        held_mark[expected_num] = 1'b0;
        add_ack(srr_pkg::KIND_ACK, expected_num, 1'b1, held_word[expected_num]);
        expected_num = expected_num + 3'd1;
        released++;
      end
    end else if (int'(seq_gap) < WIN) begin
      if (!held_mark[sq]) begin
        held_word[sq] = payload;
        held_mark[sq] = 1'b1;
        add_ack(srr_pkg::KIND_ACK, sq, 1'b0, 32'h0);
      end
      if (!held_mark[expected_num])
        add_ack(srr_pkg::KIND_NACK, expected_num, 1'b0, 32'h0);
    end
    if (frame_ack_count > 0)
      frame_acks[frame_ack_count-1].last = 1'b1;
  endtask

  // Offer one frame, wait for its transaction, then queue what it should cause
  task automatic send_frame(input frame_row_t row, output int n_acks);
    while (!quiet && $urandom_range(0, 99) < 31) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= srr_pkg::IN_TDATA_W'({row.payload, row.seq});
    s_axis_tuser  <= row.crc_ok;
    do @(posedge clk_i); while (!s_axis_tready);
    compute_acks(row.seq, row.crc_ok, row.payload);
    if (row.fixed) begin
      n_acks = row.has_ack;
      if (row.has_ack)
        pending_acks.push_back('{row.kind, row.ack_seq, row.deliver, row.out_data, 1'b1});
    end else begin
      n_acks = frame_ack_count;
      for (int i = 0; i < frame_ack_count; i++)
        pending_acks.push_back(frame_acks[i]);
    end
  endtask

  // Result side: check every transaction, idle at random, honour hold-off requests
  initial begin
    int   hold_left;
    int   holds_seen;
    ack_t got;
    ack_t want;
    hold_left     = 0;
    holds_seen    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tuser[0], m_axis_tdata[2:0], m_axis_tuser[1], m_axis_tdata[34:3],
                m_axis_tlast};
        if (pending_acks.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: kind %0d seq %0d deliver %0d data %h last %0d",
                     got.kind, got.ack_seq, got.deliver, got.out_data, got.last);
        end else begin
          want = pending_acks.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch: expected kind %0d seq %0d deliver %0d data %h last %0d",
                       want.kind, want.ack_seq, want.deliver, want.out_data, want.last);
              $display("                 got kind %0d seq %0d deliver %0d data %h last %0d",
                       got.kind, got.ack_seq, got.deliver, got.out_data, got.last);
            end
          end
        end
      end
      if (holds_seen != hold_requests) begin
        holds_seen = hold_requests;
        hold_left  = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet || ($urandom_range(0, 99) >= 31);
      end
    end
  end

  initial begin
    int         acked_frames;
    int         n_acks;
    int         pick;
    frame_row_t row;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    mismatches    = 0;
    hold_requests = 0;
    quiet         = 1'b0;
    acked_frames  = 0;
    expected_num  = 3'd0;
    for (int i = 0; i < SEQ_N; i++) begin
      held_mark[i] = 1'b0;
      held_word[i] = 32'h0;
    end

    // seq, crc_ok, payload, fixed, has_ack, kind, ack_seq, deliver, out_data
    directed_rows = '{
      // corrupt frame straight after reset
      '{3'd0, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1, srr_pkg::KIND_NACK, 3'd0, 1'b0, 32'h0},
      '{3'd0, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, srr_pkg::KIND_ACK, 3'd0, 1'b1, 32'hFFFF_FFFF},
      // behind, and just beyond, the window
      '{3'd7, 1'b1, 32'h0000_0000, 1'b1, 1'b0, srr_pkg::KIND_ACK, 3'd0, 1'b0, 32'h0},
      '{3'd5, 1'b1, 32'h0000_0000, 1'b1, 1'b0, srr_pkg::KIND_ACK, 3'd0, 1'b0, 32'h0},
      // hold three ahead, one of them twice, then fill the gap
      '{3'd4, 1'b1, 32'hA5A5_A5A5, 1'b0, 1'b0, srr_pkg::KIND_ACK, 3'd0, 1'b0, 32'h0},
      '{3'd4, 1'b1, 32'h5A5A_5A5A, 1'b0, 1'b0, srr_pkg::KIND_ACK, 3'd0, 1'b0, 32'h0},
      '{3'd3, 1'b1, 32'h0000_0000, 1'b0, 1'b0, srr_pkg::KIND_ACK, 3'd0, 1'b0, 32'h0},
      '{3'd2, 1'b1, 32'h8000_0001, 1'b0, 1'b0, srr_pkg::KIND_ACK, 3'd0, 1'b0, 32'h0},
      '{3'd1, 1'b1, 32'h0000_0000, 1'b0, 1'b0, srr_pkg::KIND_ACK, 3'd0, 1'b0, 32'h0},
      '{3'd5, 1'b0, 32'h7FFF_FFFE, 1'b1, 1'b1, srr_pkg::KIND_NACK, 3'd5, 1'b0, 32'h0},
      // hold across the wrap of the sequence space
      '{3'd7, 1'b1, 32'h1234_5678, 1'b0, 1'b0, srr_pkg::KIND_ACK, 3'd0, 1'b0, 32'h0},
      '{3'd0, 1'b1, 32'hDEAD_BEEF, 1'b0, 1'b0, srr_pkg::KIND_ACK, 3'd0, 1'b0, 32'h0},
      '{3'd6, 1'b1, 32'h0F0F_0F0F, 1'b0, 1'b0, srr_pkg::KIND_ACK, 3'd0, 1'b0, 32'h0},
      '{3'd5, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, srr_pkg::KIND_ACK, 3'd0, 1'b0, 32'h0},
      '{3'd1, 1'b1, 32'h0000_0001, 1'b1, 1'b1, srr_pkg::KIND_ACK, 3'd1, 1'b1, 32'h0000_0001},
      '{3'd2, 1'b0, 32'h0000_0000, 1'b1, 1'b1, srr_pkg::KIND_NACK, 3'd2, 1'b0, 32'h0},
      // a held frame that is not next after the in-order one
      '{3'd4, 1'b1, 32'hCAFE_F00D, 1'b0, 1'b0, srr_pkg::KIND_ACK, 3'd0, 1'b0, 32'h0},
      '{3'd2, 1'b1, 32'h0000_0000, 1'b1, 1'b1, srr_pkg::KIND_ACK, 3'd2, 1'b1, 32'h0},
      '{3'd3, 1'b1, 32'h0000_0001, 1'b0, 1'b0, srr_pkg::KIND_ACK, 3'd0, 1'b0, 32'h0},
      '{3'd1, 1'b1, 32'h0000_0000, 1'b1, 1'b0, srr_pkg::KIND_ACK, 3'd0, 1'b0, 32'h0}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < N_ROWS; r++)
      send_frame(directed_rows[r], n_acks);

    // let the directed results drain before the random part
    s_axis_tvalid <= 1'b0;
    while (pending_acks.size() > 0) @(posedge clk_i);

    while (acked_frames < RAND_ACKED) begin
      pick = $urandom_range(0, 99);
      row  = '0;
      row.crc_ok  = (pick >= 12);
      row.payload = $urandom;
      // mostly frames in the window so that holds and releases build up
      if (pick < 75)
        row.seq = expected_num + 3'($urandom_range(0, WIN - 1));
      else
        row.seq = 3'($urandom_range(0, SEQ_N - 1));
      send_frame(row, n_acks);
      if (n_acks > 0) begin
        acked_frames++;
        if (acked_frames == 25)
          hold_requests++;
        if (acked_frames == 45) begin
          s_axis_tvalid <= 1'b0;
          while (pending_acks.size() > 0) @(posedge clk_i);
        end
        quiet = (acked_frames >= 60 && acked_frames < 85);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending_acks.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && pending_acks.size() == 0)
      $display("selective_repeat_receiver_test OK");
    else
      $display("selective_repeat_receiver_test NOT OK");
    $finish;
  end

endmodule

### files.f
rtl/srr_pkg.sv
rtl/srr_front.sv
rtl/srr_back.sv
rtl/selective_repeat_receiver.sv
tb/sv/selective_repeat_receiver_test.sv
